// ===== hw/rtl/lzw_pkg.sv =====
// shared types and constants of the lzw encoder
package lzw_pkg;
    localparam int CODE_BITS  = 12;
    localparam logic [11:0] FIRST_CODE = 12'd256;
    localparam logic [11:0] END_CODE   = 12'd4095;
    localparam logic [11:0] LAST_CODE  = 12'd4094;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_beat;

    // controller to datapath
    typedef struct packed {
        logic take_in;      // latch input beat
        logic start_probe;  // compute first slot
        logic issue_read;   // read memory at probe index
        logic step_probe;   // advance probe index
        logic do_insert;    // write new entry
        logic hit_update;   // current code from slot
        logic miss_update;  // current code from byte
        logic first_update; // first byte of stream
        logic pack_cur;     // pack current code
        logic pack_end;     // pack end marker
        logic pack_zero;    // pack zero code
        logic pack_last;    // last packed code of this item
        logic clr_start;    // begin clearing pass
        logic clr_step;     // clear one entry
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic have_first;
        logic eos;
        logic slot_empty;
        logic slot_match;
        logic exhausted;
        logic clr_done;
        logic fifo_room;   // room for two more bytes
        logic fifo_empty;
    } t_stat;
endpackage

// ===== hw/rtl/lzw_if.sv =====
// valid/ready channel interfaces
interface lzw_in_if;
    logic                valid;
    logic                ready;
    lzw_pkg::t_in_beat   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lzw_out_if;
    logic                valid;
    logic                ready;
    lzw_pkg::t_out_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lzw_ctrl.sv =====
// controller state machine of the lzw encoder
module lzw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lzw_pkg::t_stat i_stat,
    output lzw_pkg::t_ctrl o_ctrl
);
    import lzw_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_MISS  = 4'd5;
    localparam logic [3:0] S_FL0   = 4'd6;
    localparam logic [3:0] S_FL1   = 4'd7;
    localparam logic [3:0] S_FL2   = 4'd8;
    localparam logic [3:0] S_DRAIN = 4'd9;
    localparam logic [3:0] S_START = 4'd10;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_START: begin
                o_ctrl.clr_start = 1'b1;
                n_state = S_CLEAR;
            end
            S_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.take_in = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (!i_stat.have_first) begin
                    o_ctrl.first_update = 1'b1;
                    n_state = i_stat.eos ? S_FL0 : S_IDLE;
                end else begin
                    o_ctrl.start_probe = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_ctrl.issue_read = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.slot_empty || i_stat.exhausted) begin
                    n_state = S_MISS;
                end else if (i_stat.slot_match) begin
                    o_ctrl.hit_update = 1'b1;
                    n_state = i_stat.eos ? S_FL0 : S_IDLE;
                end else begin
                    o_ctrl.step_probe = 1'b1;
                    n_state = S_READ;
                end
            end
            S_MISS: begin
                if (i_stat.fifo_room) begin
                    o_ctrl.do_insert   = i_stat.slot_empty;
                    o_ctrl.pack_cur    = 1'b1;
                    o_ctrl.pack_last   = !i_stat.eos;
                    o_ctrl.miss_update = 1'b1;
                    n_state = i_stat.eos ? S_FL0 : S_IDLE;
                end
            end
            S_FL0: begin
                if (i_stat.fifo_room) begin
                    o_ctrl.pack_cur = 1'b1;
                    n_state = S_FL1;
                end
            end
            S_FL1: begin
                if (i_stat.fifo_room) begin
                    o_ctrl.pack_end = 1'b1;
                    n_state = S_FL2;
                end
            end
            S_FL2: begin
                if (i_stat.fifo_room) begin
                    o_ctrl.pack_zero = 1'b1;
                    o_ctrl.pack_last = 1'b1;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.fifo_empty) n_state = S_START;
            end
            default: n_state = S_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_START;
        else          r_state <= n_state;
    end
endmodule

// ===== hw/rtl/lzw_dpath.sv =====
// dictionary, probe logic, code packer and output queue
module lzw_dpath #(
    parameter int HASH_SLOTS = 5021
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzw_pkg::t_in_beat  i_in,
    input  lzw_pkg::t_ctrl     i_ctrl,
    output lzw_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lzw_pkg::t_out_beat o_out
);
    import lzw_pkg::*;

    localparam int IW = $clog2(HASH_SLOTS);
    localparam int CW = $clog2(HASH_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(HASH_SLOTS - 1);

    // dictionary memories, code 0 marks empty (valid codes are >= 256)
    logic [11:0] m_code   [HASH_SLOTS];
    logic [11:0] m_prefix [HASH_SLOTS];
    logic [7:0]  m_char   [HASH_SLOTS];

    logic [7:0]    r_byte;
    logic          r_eos;
    logic [11:0]   r_cur;
    logic          r_have_first;
    logic [11:0]   r_next_free;
    logic [3:0]    r_nib;
    logic          r_nib_valid;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_step;
    logic [CW-1:0] r_probes;
    logic [11:0]   r_rd_code, r_rd_prefix;
    logic [7:0]    r_rd_char;
    logic [IW-1:0] r_clr_idx;
    logic          r_clr_done;

    // first slot: hash reduced below the table size
    logic [15:0] hash_raw;
    logic [16:0] hash_sub;
    logic [IW-1:0] hash_idx;
    always_comb begin
        hash_raw = {4'd0, r_byte, 4'd0} ^ {4'd0, r_cur};
        hash_sub = {1'b0, hash_raw} - 17'(HASH_SLOTS);
        // raw < 4096 <= HASH_SLOTS - 3 so reduction never needed above 4099
        hash_idx = hash_sub[16] ? IW'(hash_raw) : IW'(hash_sub[15:0]);
    end

    // probe index step back with wrap
    logic [IW:0] idx_dec;
    assign idx_dec = {1'b0, r_idx} - {1'b0, r_step};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in) begin
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_stream;
        end
        if (i_ctrl.start_probe) begin
            r_idx    <= hash_idx;
            r_step   <= (hash_idx == '0) ? IW'(1) : IW'(HASH_SLOTS - 32'(hash_idx));
            r_probes <= '0;
        end else if (i_ctrl.step_probe) begin
            r_idx    <= idx_dec[IW] ? IW'(idx_dec + (IW+1)'(HASH_SLOTS)) : idx_dec[IW-1:0];
            r_probes <= r_probes + CW'(1);
        end
        if (i_ctrl.issue_read) begin
            r_rd_code   <= m_code[r_idx];
            r_rd_prefix <= m_prefix[r_idx];
            r_rd_char   <= m_char[r_idx];
        end
    end

    // code memory: insert and clearing pass share one write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_step) begin
            m_code[r_clr_idx] <= '0;
        end else if (i_ctrl.do_insert && r_next_free <= LAST_CODE) begin
            m_code[r_idx]   <= r_next_free;
            m_prefix[r_idx] <= r_cur;
            m_char[r_idx]   <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (i_ctrl.clr_start) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (i_ctrl.clr_step) begin
            r_clr_done <= (r_clr_idx == LAST_IDX - IW'(1)) || (r_clr_idx == LAST_IDX);
            if (r_clr_idx != LAST_IDX) r_clr_idx <= r_clr_idx + IW'(1);
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr_start) begin
            r_cur        <= '0;
            r_have_first <= 1'b0;
            r_next_free  <= FIRST_CODE;
        end else begin
            if (i_ctrl.first_update) begin
                r_cur        <= {4'd0, r_byte};
                r_have_first <= 1'b1;
            end
            if (i_ctrl.hit_update)  r_cur <= r_rd_code;
            if (i_ctrl.miss_update) r_cur <= {4'd0, r_byte};
            if (i_ctrl.do_insert && r_next_free <= LAST_CODE)
                r_next_free <= r_next_free + 12'd1;
        end
    end

    // packer: selected code into one or two bytes
    logic [11:0] pk_code;
    logic        pk_go;
    assign pk_go   = i_ctrl.pack_cur | i_ctrl.pack_end | i_ctrl.pack_zero;
    assign pk_code = i_ctrl.pack_end ? END_CODE : (i_ctrl.pack_zero ? 12'd0 : r_cur);

    // output queue of four beats
    t_out_beat   q_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic [2:0]  n_push;
    t_out_beat   b0, b1;
    logic        pop;

    always_comb begin
        b0 = '0;
        b1 = '0;
        n_push = '0;
        if (pk_go) begin
            if (r_nib_valid) begin
                b0.out_byte = {r_nib, pk_code[11:8]};
                b1.out_byte = pk_code[7:0];
                b1.run_last = i_ctrl.pack_last;
                b1.stream_done = i_ctrl.pack_last & i_ctrl.pack_zero;
                n_push = 3'd2;
            end else begin
                b0.out_byte = pk_code[11:4];
                b0.run_last = i_ctrl.pack_last;
                b0.stream_done = i_ctrl.pack_last & i_ctrl.pack_zero;
                n_push = 3'd1;
            end
        end
    end

    assign pop = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (n_push != 3'd0) q_mem[r_wp] <= b0;
        if (n_push == 3'd2) q_mem[r_wp + 2'd1] <= b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_nib <= '0;
            r_nib_valid <= 1'b0;
        end else begin
            r_wp  <= r_wp + n_push[1:0];
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + n_push - {2'd0, pop};
            if (i_ctrl.clr_start) begin
                r_nib_valid <= 1'b0;
                r_nib <= '0;
            end else if (pk_go) begin
                r_nib_valid <= !r_nib_valid;
                r_nib <= pk_code[3:0];
            end
        end
    end

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out       = q_mem[r_rp];

    always_comb begin
        o_stat.have_first = r_have_first;
        o_stat.eos        = r_eos;
        o_stat.exhausted  = (r_probes == CW'(HASH_SLOTS));
        o_stat.slot_empty = (r_rd_code == 12'd0) && (r_probes != CW'(HASH_SLOTS));
        o_stat.slot_match = (r_rd_prefix == r_cur) && (r_rd_char == r_byte);
        o_stat.clr_done   = r_clr_done;
        o_stat.fifo_room  = (r_cnt <= 3'd2);
        o_stat.fifo_empty = (r_cnt == 3'd0);
    end
endmodule

// ===== hw/rtl/lzw_encoder_12bit.sv =====
// top level of the 12-bit lzw encoder
//  channel   dir  payload                              handshake
//  in_ch     in   data_byte, end_of_stream             valid/ready
//  out_ch    out  out_byte, run_last, stream_done      valid/ready
// each byte passes through the idle and hash states, then a read and a check state
// per dictionary probe and the miss state on a miss; the first byte of a stream needs no probe
// the end-of-stream flush then packs three codes, waits for the output queue
// to drain and runs a clearing pass over every entry of the table
// the same clearing pass follows reset; no byte is taken during it
// a stalled output holds the block once its four-beat queue lacks room
module lzw_encoder_12bit #(
    parameter int HASH_SLOTS = 5021
) (
    input logic      i_clk,
    input logic      i_rst_n,
    lzw_in_if.sink   in_ch,
    lzw_out_if.source out_ch
);
    import lzw_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    lzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    lzw_dpath #(.HASH_SLOTS(HASH_SLOTS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.data),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_out       (out_ch.data)
    );

    // no input is taken while a flush is still pushing codes
    a_no_take_in_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.take_in && (ctrl.pack_cur || ctrl.pack_end || ctrl.pack_zero)))
        else $error("input taken during packing");
    // packing only when the queue has room
    a_pack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.pack_cur || ctrl.pack_end || ctrl.pack_zero) |-> stat.fifo_room)
        else $error("packing into full queue");
    // clearing never overlaps dictionary insertion
    a_clr_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.clr_step && ctrl.do_insert))
        else $error("insert during clear");
endmodule
